>>> rtl/dec_pkg.sv
package dec_pkg;

  localparam int RAD_W  = 65;  // dx^2 + dy^2
  localparam int DIST_W = 33;  // rounded centre distance
  localparam int LAT    = 77;  // input to output register, in cycles

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_vx;
    logic signed [31:0] first_vy;
    logic        [31:0] first_mass;
    logic        [30:0] first_diameter;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_vx;
    logic signed [31:0] second_vy;
    logic        [31:0] second_mass;
    logic        [30:0] second_diameter;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_vx;
    logic signed [31:0] new_first_vy;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_vx;
    logic signed [31:0] new_second_vy;
    logic               coincident;
  } out_t;

endpackage

>>> rtl/dec_delay.sv
module dec_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[N-1];

endmodule

>>> rtl/dec_sqrt.sv
module dec_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [dec_pkg::RAD_W-1:0]    rad,
  output logic [dec_pkg::DIST_W-1:0]   root
);

  localparam int RW = dec_pkg::RAD_W;
  localparam int DW = dec_pkg::DIST_W;
  localparam int NS = DW;        // one root bit per stage
  localparam int MW = DW + 1;    // partial remainder

  logic [MW-1:0] rem_r  [NS];
  logic [DW-1:0] root_r [NS];
  logic [RW-1:0] rad_r  [NS];
  logic [DW-1:0] dist_r;

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int P = NS - 1 - i;
    logic [MW-1:0]   rin;
    logic [DW-1:0]   oin;
    logic [RW-1:0]   ain;
    logic [2*DW-1:0] pad;
    logic [MW+1:0]   sh;
    logic [MW+1:0]   trial;
    logic [MW+1:0]   diff;
    logic            take;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign ain = rad;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign oin = root_r[i-1];
      assign ain = rad_r[i-1];
    end

    assign pad   = (2*DW)'(ain);
    assign sh    = {rin, pad[2*P+1 -: 2]};
    assign trial = {1'b0, oin, 2'b01};
    assign take  = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? diff[MW-1:0] : sh[MW-1:0];
        root_r[i] <= {oin[DW-2:0], take};
        rad_r[i]  <= ain;
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= root_r[NS-1] + DW'(rem_r[NS-1] > {1'b0, root_r[NS-1]});
    end
  end

  assign root = dist_r;

endmodule

>>> rtl/dec_div.sv
module dec_div #(
  parameter int NW = 63,
  parameter int DW = 33,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // restoring division, one quotient bit per stage; num >> QW must be below den

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rin;
    logic [QW-1:0] lin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [QW-1:0] qnxt;
    logic [DW:0]   wide;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rin = DW'(num[NW-1:QW]);
      assign lin = num[QW-1:0];
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign lin = low_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
    end

    assign wide = {rin, lin[QW-1-k]};
    assign take = wide >= {1'b0, din};
    assign diff = wide - {1'b0, din};

    always_comb begin
      qnxt = qin;
      qnxt[QW-1-k] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DW-1:0] : wide[DW-1:0];
        low_r[k] <= lin;
        den_r[k] <= din;
        quo_r[k] <= qnxt;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

>>> rtl/disc_elastic_collision.sv
// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    dec_pkg::in_t, one disc pair
// out_     output     out_valid / out_ready  dec_pkg::out_t, resolved pair
//
// One word enters per cycle unless the pipeline holds; results leave in arrival order.
// The latency is set by the bit-per-stage square root (34 stages), the normal divider
// (31 stages) and the multiply and round stages after it.
// Reset clears the valid bits only. The whole pipeline holds while out_valid is high
// and out_ready is low; in_ready is low exactly then.
module disc_elastic_collision (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dec_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dec_pkg::out_t  out_data
);

  localparam int LAT = dec_pkg::LAT;
  localparam int DW  = dec_pkg::DIST_W;

  typedef struct packed {
    logic [31:0] dmx;
    logic [31:0] dmy;
    logic        sx;
    logic        sy;
    logic [31:0] ddsum;
    logic        coinc;
  } geo_t;

  typedef struct packed {
    logic signed [35:0] t;
    logic               sx;
    logic               sy;
    logic               coinc;
  } side_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } nrm_t;

  typedef struct packed {
    dec_pkg::in_t inp;
    logic         coinc;
  } pass_t;

  typedef struct packed {
    logic signed [35:0] mx;
    logic signed [35:0] my;
  } mxy_t;

  function automatic logic signed [39:0] rnd30(input logic signed [72:0] p);
    logic [72:0] m;
    logic [72:0] r;
    m = p[72] ? 73'(-p) : 73'(p);
    r = (m + (73'(1) << 29)) >> 30;
    return p[72] ? -$signed({1'b0, r[38:0]}) : $signed({1'b0, r[38:0]});
  endfunction

  function automatic logic signed [39:0] rnd32(input logic signed [72:0] p);
    logic [72:0] m;
    logic [72:0] r;
    m = p[72] ? 73'(-p) : 73'(p);
    r = (m + (73'(1) << 31)) >> 32;
    return p[72] ? -$signed({1'b0, r[38:0]}) : $signed({1'b0, r[38:0]});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] s;
    if (v > 40'sd2147483647) begin
      s = 32'h7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      s = 32'h8000_0000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  logic adv;
  logic [LAT-1:0] vld_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: differences, mass factor dividends
  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic [32:0] msum_w;
  geo_t        geo_nxt;
  geo_t        geo1_r;
  logic [63:0] fn1_r;
  logic [63:0] fn2_r;
  logic [32:0] msum1_r;
  logic        fz1_r;

  always_comb begin
    dx_w = {in_data.second_x[31], in_data.second_x} - {in_data.first_x[31], in_data.first_x};
    dy_w = {in_data.second_y[31], in_data.second_y} - {in_data.first_y[31], in_data.first_y};
    msum_w = {1'b0, in_data.first_mass} + {1'b0, in_data.second_mass};
    geo_nxt.dmx   = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
    geo_nxt.dmy   = dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
    geo_nxt.sx    = dx_w[32];
    geo_nxt.sy    = dy_w[32];
    geo_nxt.ddsum = {1'b0, in_data.first_diameter} + {1'b0, in_data.second_diameter};
    geo_nxt.coinc = (in_data.first_x == in_data.second_x) &&
                    (in_data.first_y == in_data.second_y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo1_r  <= geo_nxt;
      fn1_r   <= {1'b0, in_data.second_mass, 31'b0} + 64'(msum_w[32:1]);
      fn2_r   <= {1'b0, in_data.first_mass, 31'b0} + 64'(msum_w[32:1]);
      msum1_r <= msum_w;
      fz1_r   <= (msum_w == '0);
    end
  end

  // mass factors, ready at stage 33
  logic [31:0] fq1_w;
  logic [31:0] fq2_w;

  dec_div #(.NW(64), .DW(33), .QW(32)) u_div_f1 (
    .clk(clk), .en(adv), .num(fn1_r), .den(msum1_r), .quo(fq1_w)
  );

  dec_div #(.NW(64), .DW(33), .QW(32)) u_div_f2 (
    .clk(clk), .en(adv), .num(fn2_r), .den(msum1_r), .quo(fq2_w)
  );

  logic [63:0] fq73_w;
  logic        fz73_w;

  dec_delay #(.W(64), .N(40)) u_dly_fq (
    .clk(clk), .en(adv), .d({fq1_w, fq2_w}), .q(fq73_w)
  );

  dec_delay #(.W(1), .N(72)) u_dly_fz (
    .clk(clk), .en(adv), .d(fz1_r), .q(fz73_w)
  );

  // stages 2-3: squared distance
  logic [63:0] sqx_r;
  logic [63:0] sqy_r;
  logic [dec_pkg::RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= geo1_r.dmx * geo1_r.dmx;
      sqy_r <= geo1_r.dmy * geo1_r.dmy;
      rad_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    end
  end

  logic [DW-1:0] dist_w;

  dec_sqrt u_sqrt (
    .clk(clk), .en(adv), .rad(rad_r), .root(dist_w)
  );

  geo_t geo37_w;

  dec_delay #(.W($bits(geo_t)), .N(36)) u_dly_geo (
    .clk(clk), .en(adv), .d(geo1_r), .q(geo37_w)
  );

  // stage 38: normal dividends and twice the overlap
  logic [62:0]   numx_r;
  logic [62:0]   numy_r;
  logic [DW-1:0] den_r;
  side_t         side38_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      numx_r <= {1'b0, geo37_w.dmx, 30'b0} + 63'(dist_w[DW-1:1]);
      numy_r <= {1'b0, geo37_w.dmy, 30'b0} + 63'(dist_w[DW-1:1]);
      den_r  <= dist_w;
      side38_r.t     <= $signed({4'b0, geo37_w.ddsum}) - $signed({2'b0, dist_w, 1'b0});
      side38_r.sx    <= geo37_w.sx;
      side38_r.sy    <= geo37_w.sy;
      side38_r.coinc <= geo37_w.coinc;
    end
  end

  logic [30:0] qx_w;
  logic [30:0] qy_w;
  side_t       side69_w;

  dec_div #(.NW(63), .DW(33), .QW(31)) u_div_nx (
    .clk(clk), .en(adv), .num(numx_r), .den(den_r), .quo(qx_w)
  );

  dec_div #(.NW(63), .DW(33), .QW(31)) u_div_ny (
    .clk(clk), .en(adv), .num(numy_r), .den(den_r), .quo(qy_w)
  );

  dec_delay #(.W($bits(side_t)), .N(31)) u_dly_side (
    .clk(clk), .en(adv), .d(side38_r), .q(side69_w)
  );

  // stage 70: signed unit normal
  nrm_t               n70_r;
  logic signed [35:0] t70_r;
  logic               coinc70_r;
  dec_pkg::in_t       inp70_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      n70_r.nx  <= side69_w.sx ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
      n70_r.ny  <= side69_w.sy ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});
      t70_r     <= side69_w.t;
      coinc70_r <= side69_w.coinc;
    end
  end

  dec_delay #(.W($bits(dec_pkg::in_t)), .N(70)) u_dly_in (
    .clk(clk), .en(adv), .d(in_data), .q(inp70_w)
  );

  nrm_t  n75_w;
  pass_t pass76_w;

  dec_delay #(.W($bits(nrm_t)), .N(5)) u_dly_nrm (
    .clk(clk), .en(adv), .d(n70_r), .q(n75_w)
  );

  dec_delay #(.W($bits(pass_t)), .N(6)) u_dly_pass (
    .clk(clk), .en(adv), .d({inp70_w, coinc70_r}), .q(pass76_w)
  );

  // stage 71: projections and separation products
  logic signed [63:0] px1_r;
  logic signed [63:0] py1_r;
  logic signed [63:0] px2_r;
  logic signed [63:0] py2_r;
  logic signed [67:0] ptx_r;
  logic signed [67:0] pty_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r <= inp70_w.first_vx * n70_r.nx;
      py1_r <= inp70_w.first_vy * n70_r.ny;
      px2_r <= inp70_w.second_vx * n70_r.nx;
      py2_r <= inp70_w.second_vy * n70_r.ny;
      ptx_r <= t70_r * n70_r.nx;
      pty_r <= t70_r * n70_r.ny;
    end
  end

  // stage 72: normal speeds and centre moves
  logic signed [39:0] v1n_w;
  logic signed [39:0] v2n_w;
  logic signed [39:0] mx_w;
  logic signed [39:0] my_w;
  logic signed [33:0] v1n72_r;
  logic signed [33:0] v2n72_r;
  mxy_t               mxy72_r;

  always_comb begin
    v1n_w = rnd30(73'(65'(px1_r) + 65'(py1_r)));
    v2n_w = rnd30(73'(65'(px2_r) + 65'(py2_r)));
    mx_w  = rnd32(73'(ptx_r));
    my_w  = rnd32(73'(pty_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1n72_r    <= v1n_w[33:0];
      v2n72_r    <= v2n_w[33:0];
      mxy72_r.mx <= mx_w[35:0];
      mxy72_r.my <= my_w[35:0];
    end
  end

  mxy_t mxy76_w;

  dec_delay #(.W($bits(mxy_t)), .N(4)) u_dly_mxy (
    .clk(clk), .en(adv), .d(mxy72_r), .q(mxy76_w)
  );

  // stage 73: relative normal speed
  logic signed [34:0] dv73_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv73_r <= 35'(v2n72_r) - 35'(v1n72_r);
    end
  end

  // stage 74: impulse products; zero total mass means equal masses
  logic [31:0]        f1_w;
  logic [31:0]        f2_w;
  logic signed [67:0] pj1_r;
  logic signed [67:0] pj2_r;

  assign f1_w = fz73_w ? 32'h4000_0000 : fq73_w[63:32];
  assign f2_w = fz73_w ? 32'h4000_0000 : fq73_w[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pj1_r <= $signed({1'b0, f1_w}) * dv73_r;
      pj2_r <= $signed({1'b0, f2_w}) * (-dv73_r);
    end
  end

  // stage 75: impulses
  logic signed [39:0] j1_w;
  logic signed [39:0] j2_w;
  logic signed [35:0] j1_r;
  logic signed [35:0] j2_r;

  always_comb begin
    j1_w = rnd30(73'(pj1_r));
    j2_w = rnd30(73'(pj2_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_r <= j1_w[35:0];
      j2_r <= j2_w[35:0];
    end
  end

  // stage 76: velocity change products
  logic signed [67:0] pvx1_r;
  logic signed [67:0] pvy1_r;
  logic signed [67:0] pvx2_r;
  logic signed [67:0] pvy2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pvx1_r <= j1_r * n75_w.nx;
      pvy1_r <= j1_r * n75_w.ny;
      pvx2_r <= j2_r * n75_w.nx;
      pvy2_r <= j2_r * n75_w.ny;
    end
  end

  // stage 77: apply, saturate, bypass coincident centres
  dec_pkg::in_t       p_w;
  dec_pkg::out_t      res_w;
  dec_pkg::out_t      out_r;
  logic signed [39:0] dvx1_w;
  logic signed [39:0] dvy1_w;
  logic signed [39:0] dvx2_w;
  logic signed [39:0] dvy2_w;

  always_comb begin
    p_w    = pass76_w.inp;
    dvx1_w = rnd30(73'(pvx1_r));
    dvy1_w = rnd30(73'(pvy1_r));
    dvx2_w = rnd30(73'(pvx2_r));
    dvy2_w = rnd30(73'(pvy2_r));
    if (pass76_w.coinc) begin
      res_w.new_first_x   = p_w.first_x;
      res_w.new_first_y   = p_w.first_y;
      res_w.new_first_vx  = p_w.first_vx;
      res_w.new_first_vy  = p_w.first_vy;
      res_w.new_second_x  = p_w.second_x;
      res_w.new_second_y  = p_w.second_y;
      res_w.new_second_vx = p_w.second_vx;
      res_w.new_second_vy = p_w.second_vy;
      res_w.coincident    = 1'b1;
    end else begin
      res_w.new_first_x   = sat32(40'(p_w.first_x) - 40'(mxy76_w.mx));
      res_w.new_first_y   = sat32(40'(p_w.first_y) - 40'(mxy76_w.my));
      res_w.new_first_vx  = sat32(40'(p_w.first_vx) + dvx1_w);
      res_w.new_first_vy  = sat32(40'(p_w.first_vy) + dvy1_w);
      res_w.new_second_x  = sat32(40'(p_w.second_x) + 40'(mxy76_w.mx));
      res_w.new_second_y  = sat32(40'(p_w.second_y) + 40'(mxy76_w.my));
      res_w.new_second_vx = sat32(40'(p_w.second_vx) + dvx2_w);
      res_w.new_second_vy = sat32(40'(p_w.second_vy) + dvy2_w);
      res_w.coincident    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_w;
    end
  end

  assign out_data = out_r;

endmodule

>>> sim/tb_disc_elastic_collision.sv
`timescale 1ns / 1ps

module tb_disc_elastic_collision;

  localparam int NUM_RANDOM = 1530;
  localparam int QUIET_TAIL = 200;

  typedef struct {
    dec_pkg::in_t  pair;
    dec_pkg::out_t want;
    bit            typed;
  } row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  dec_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  dec_pkg::out_t out_data;

  dec_pkg::out_t resolved_q[$];
  int            mismatches;
  int            results_seen;
  int            coincident_seen;
  bit            quiet;
  bit            long_hold_req;
  row_t          rows[$];

  disc_elastic_collision DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // round(a*b / 2^sh), halves away from zero, magnitude clipped to 2^62
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] p;
    logic [63:0]  ua;
    logic [63:0]  ub;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = ua * ub;
    p   = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint div_near(longint num, logic [63:0] den);
    logic [63:0] un;
    logic [63:0] q;
    un = (num < 0) ? -num : num;
    q  = (un + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] root_near(logic [65:0] rad);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem   = (rem << 2) | rad[2*i +: 2];
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return (rem > root) ? root[63:0] + 64'd1 : root[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic dec_pkg::out_t resolve_pair(dec_pkg::in_t w);
    dec_pkg::out_t r;
    longint        x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy;
    longint        nx, ny, t, mx, my, v1n, v2n, dv, f1, f2, j1, j2;
    logic [63:0]   m1, m2, d1, d2, ux, uy, cdist, msum;
    logic [65:0]   rad;
    x1  = w.first_x;
    y1  = w.first_y;
    vx1 = w.first_vx;
    vy1 = w.first_vy;
    x2  = w.second_x;
    y2  = w.second_y;
    vx2 = w.second_vx;
    vy2 = w.second_vy;
    m1  = {32'd0, w.first_mass};
    m2  = {32'd0, w.second_mass};
    d1  = {33'd0, w.first_diameter};
    d2  = {33'd0, w.second_diameter};
    dx  = x2 - x1;
    dy  = y2 - y1;
    if (dx == 0 && dy == 0) begin
      r = '{w.first_x, w.first_y, w.first_vx, w.first_vy,
            w.second_x, w.second_y, w.second_vx, w.second_vy, 1'b1};
      return r;
    end
    ux    = (dx < 0) ? -dx : dx;
    uy    = (dy < 0) ? -dy : dy;
    rad   = 66'(ux * ux) + 66'(uy * uy);
    cdist = root_near(rad);
    if (cdist == 0) cdist = 64'd1;
    nx = div_near(dx * (64'sd1 <<< 30), cdist);
    ny = div_near(dy * (64'sd1 <<< 30), cdist);
    t  = longint'(d1 + d2) - 2 * longint'(cdist);
    mx = scaled_product(t, nx, 32);
    my = scaled_product(t, ny, 32);
    v1n  = div_near(vx1 * nx + vy1 * ny, 64'd1 << 30);
    v2n  = div_near(vx2 * nx + vy2 * ny, 64'd1 << 30);
    dv   = v2n - v1n;
    msum = m1 + m2;
    if (msum == 0) begin
      f1 = 64'sd1 <<< 30;
      f2 = 64'sd1 <<< 30;
    end else begin
      f1 = longint'((2 * m2 * (64'd1 << 30) + msum / 2) / msum);
      f2 = longint'((2 * m1 * (64'd1 << 30) + msum / 2) / msum);
    end
    j1 = scaled_product(f1, dv, 30);
    j2 = scaled_product(f2, -dv, 30);
    r.new_first_x   = clamp32(x1 - mx);
    r.new_first_y   = clamp32(y1 - my);
    r.new_first_vx  = clamp32(vx1 + scaled_product(j1, nx, 30));
    r.new_first_vy  = clamp32(vy1 + scaled_product(j1, ny, 30));
    r.new_second_x  = clamp32(x2 + mx);
    r.new_second_y  = clamp32(y2 + my);
    r.new_second_vx = clamp32(vx2 + scaled_product(j2, nx, 30));
    r.new_second_vy = clamp32(vy2 + scaled_product(j2, ny, 30));
    r.coincident    = 1'b0;
    return r;
  endfunction

  function automatic dec_pkg::in_t pair_of(int x1, int y1, int vx1, int vy1,
                                           int unsigned m1, int unsigned d1,
                                           int x2, int y2, int vx2, int vy2,
                                           int unsigned m2, int unsigned d2);
    dec_pkg::in_t w;
    w = '{x1, y1, vx1, vy1, m1, d1[30:0], x2, y2, vx2, vy2, m2, d2[30:0]};
    return w;
  endfunction

  function automatic int rand_near(int base, int span);
    return base + $signed($urandom_range(2 * span)) - span;
  endfunction

  // mostly touching or overlapping discs with random content, some wide-open noise
  function automatic dec_pkg::in_t random_pair();
    dec_pkg::in_t w;
    logic [383:0] noise;
    int unsigned  kind;
    int           span;
    kind  = $urandom_range(99);
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w     = noise[$bits(dec_pkg::in_t)-1:0];
    if (w.first_mass == 0) w.first_mass = 32'd1;
    if (w.second_mass == 0) w.second_mass = 32'd1;
    if (kind < 65) begin
      span             = 1 << $urandom_range(4, 22);
      w.first_x        = rand_near(0, 32'h3fff_ffff);
      w.first_y        = rand_near(0, 32'h3fff_ffff);
      w.second_x       = rand_near(w.first_x, span);
      w.second_y       = rand_near(w.first_y, span);
      w.first_diameter  = 31'($urandom_range(2 * span));
      w.second_diameter = 31'($urandom_range(2 * span));
      w.first_vx       = rand_near(0, 1 << $urandom_range(4, 30));
      w.first_vy       = rand_near(0, 1 << $urandom_range(4, 30));
      w.second_vx      = rand_near(0, 1 << $urandom_range(4, 30));
      w.second_vy      = rand_near(0, 1 << $urandom_range(4, 30));
      if ($urandom_range(3) == 0) w.first_mass = $urandom_range(1, 32'h0004_0000);
      if ($urandom_range(3) == 0) w.second_mass = w.first_mass;
    end else if (kind < 72) begin
      w.second_x = w.first_x;
      w.second_y = w.first_y;
    end else if (kind < 80) begin
      // hold one axis equal so the normal is axis aligned
      if (kind[0]) w.second_x = w.first_x;
      else w.second_y = w.first_y;
    end else if (kind < 85) begin
      w.first_x  = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      w.first_y  = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      w.second_x = -w.first_x - 1;
      w.second_y = -w.first_y - 1;
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      dec_pkg::out_t want;
      results_seen++;
      if (out_data.coincident === 1'b1) coincident_seen++;
      if (resolved_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t result word with nothing expected", $realtime);
      end else begin
        want = resolved_q.pop_front();
        check_field("new_first_x", want.new_first_x, out_data.new_first_x);
        check_field("new_first_y", want.new_first_y, out_data.new_first_y);
        check_field("new_first_vx", want.new_first_vx, out_data.new_first_vx);
        check_field("new_first_vy", want.new_first_vy, out_data.new_first_vy);
        check_field("new_second_x", want.new_second_x, out_data.new_second_x);
        check_field("new_second_y", want.new_second_y, out_data.new_second_y);
        check_field("new_second_vx", want.new_second_vx, out_data.new_second_vx);
        check_field("new_second_vy", want.new_second_vy, out_data.new_second_vy);
        check_field("coincident", 32'(want.coincident), 32'(out_data.coincident));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none near the end
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end else if (hold == 0 && !quiet && $urandom_range(4) == 0) begin
        hold = $urandom_range(1, 3);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(dec_pkg::in_t w, dec_pkg::out_t want, bit typed);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    resolved_q.push_back(typed ? want : resolve_pair(w));
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_row(dec_pkg::in_t w, bit typed, dec_pkg::out_t want);
    row_t r;
    r.pair  = w;
    r.typed = typed;
    r.want  = want;
    rows.push_back(r);
  endtask

  initial begin
    dec_pkg::in_t  w;
    dec_pkg::out_t want;
    int            tail_wait;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    mismatches      = 0;
    results_seen    = 0;
    coincident_seen = 0;
    quiet           = 1'b0;
    long_hold_req   = 1'b0;

    // coincident centres, at the extremes and at the origin, pass straight through
    w = pair_of(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'd1, 0);
    add_row(w, 1, '{w.first_x, w.first_y, w.first_vx, w.first_vy, w.second_x,
                    w.second_y, w.second_vx, w.second_vy, 1'b1});
    w = pair_of(0, 0, 0, 0, 32'd1, 0, 0, 0, 0, 0, 32'd1, 0);
    add_row(w, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1});
    // just touching, at rest: nothing moves
    w = pair_of(0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000);
    add_row(w, 1, '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 1'b0});
    // head-on, equal masses: velocities swap
    w = pair_of(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000,
                32'h10000);
    add_row(w, 1, '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 1'b0});
    want = '0;
    // deep overlap, gap between discs, separating discs, mass extremes, far apart
    add_row(pair_of(0, 0, 32'h10000, 32'h8000, 32'h10000, 32'h7fffffff, 32'h100, 32'h80,
                    0, 0, 32'hffffffff, 32'h7fffffff), 0, want);
    add_row(pair_of(0, 0, 0, 0, 32'd1, 0, 32'h50000, 32'h30000, 32'h10000, 0, 32'd1, 0),
            0, want);
    add_row(pair_of(0, 0, 32'hffff0000, 0, 32'h10000, 32'h20000, 32'h10000, 0, 32'h10000,
                    0, 32'h10000, 32'h20000), 0, want);
    add_row(pair_of(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    32'hffffffff, 32'h7fffffff), 0, want);
    add_row(pair_of(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'd1, 32'h7fffffff,
                    32'h80000000, 1, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'h7fffffff),
            0, want);
    add_row(pair_of(0, 0, 32'h12345, 32'hfedcb, 32'h30000, 32'h18000, 1, 1, 32'h7fffffff,
                    32'h80000000, 32'h10000, 32'h18000), 0, want);
    add_row(pair_of(5, 7, 0, 0, 32'hffffffff, 1, 5, 8, 32'h80000000, 0, 32'hffffffff, 1),
            0, want);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_word(rows[i].pair, rows[i].want, rows[i].typed);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) begin
        // drain fully before carrying on
        @(negedge clk);
        in_valid <= 1'b0;
        while (resolved_q.size() != 0) @(negedge clk);
      end
      if (i == 600) long_hold_req = 1'b1;
      if (i == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_word(random_pair(), '0, 1'b0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (resolved_q.size() != 0) @(posedge clk);
    tail_wait = dec_pkg::LAT + 20;
    repeat (tail_wait) @(posedge clk);

    $display("Resolved %0d disc pairs (%0d with coincident centres), directed and random,",
             results_seen, coincident_seen);
    $display("with stalls on both channels, a drain pause and a long receiver hold-off.");
    if (mismatches == 0) begin
      $display("tb_disc_elastic_collision OK");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("tb_disc_elastic_collision NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", resolved_q.size());
    $display("tb_disc_elastic_collision NOT OK");
    $finish;
  end

endmodule
